/* src/pmns_pkg.sv */
`default_nettype none

package pmns_pkg;

   // Default geometry of the sampler.
   localparam int SLOTS_DEF        = 12;
   localparam int RETURN_DELAY_DEF = 2;

   // Fixed widths of the item fields.
   localparam int WORD_W      = 16;
   localparam int SLOT_PORT_W = 4;
   localparam int CHAN_W      = 6;
   localparam int MAP_SLOTS   = 16;
   localparam int LOW_SLOTS   = 10;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 60;
   localparam int MAP_LOW_W  = 60;
   localparam int MAP_HIGH_W = 36;

   localparam logic [CSR_IDX_W-1:0] CSR_CHAN_MAP_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAN_MAP_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ENABLE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B_OUTER  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B_MID    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_FB_NEAR  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_FB_FAR   = 3'd6;

   // Register reset values.
   localparam logic [MAP_LOW_W-1:0]  MAP_LOW_RST   = 60'd219304678793425025;
   localparam logic [MAP_HIGH_W-1:0] MAP_HIGH_RST  = 36'd909;
   localparam logic signed [15:0]    B_OUTER_RST   = 16'sd15886;
   localparam logic signed [15:0]    B_MID_RST     = -16'sd30217;
   localparam logic signed [15:0]    FB_NEAR_RST   = 16'sd30215;
   localparam logic signed [15:0]    FB_FAR_RST    = -16'sd15386;

   // Notch gains in Q2.14.
   typedef struct packed {
      logic signed [15:0] b_outer;
      logic signed [15:0] b_mid;
      logic signed [15:0] fb_near;
      logic signed [15:0] fb_far;
   } pmns_coef_type;

   // One history entry per slot: two inputs and two Q.8 outputs, oldest first.
   typedef struct packed {
      logic signed [15:0] x0;
      logic signed [15:0] x1;
      logic signed [31:0] y0;
      logic signed [31:0] y1;
   } pmns_hist_type;

   // Pipeline strobes from the sequencer to the filter datapath.
   typedef struct packed {
      logic rd_en;
      logic s1_load;
      logic wr_en;
   } pmns_ctl_type;

endpackage

`default_nettype wire

/* src/pipelined_multichannel_notch_sampler.sv */
`default_nettype none

// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  req_rx_word
// rsp       out        rsp_valid / rsp_stall  rsp_next_cmd, rsp_sample_valid, rsp_sample_slot,
//                                             rsp_filtered_sample, rsp_set_done
// csr       in         csr_wr_en              csr_index, csr_wdata
//
// One item per clock cycle sustained while rsp_stall is low, since every
// stage hands on each cycle; a result passes the history read in stage 1,
// the products in stage 2, then sum and clamp into the output register.
// The per-slot history lives in one memory; a valid bit per slot clears it
// at reset, so there is no clearing pass and items are taken right away.
// A stalled result holds in the output register while the stages behind it
// close up; req_stall rises only when all three stages are full.

module pipelined_multichannel_notch_sampler #(
   parameter int SLOTS        = pmns_pkg::SLOTS_DEF,
   parameter int RETURN_DELAY = pmns_pkg::RETURN_DELAY_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [pmns_pkg::WORD_W-1:0]    req_rx_word,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [pmns_pkg::WORD_W-1:0]                rsp_next_cmd,
   output logic                                       rsp_sample_valid,
   output logic [pmns_pkg::SLOT_PORT_W-1:0]           rsp_sample_slot,
   output logic signed [pmns_pkg::WORD_W-1:0]         rsp_filtered_sample,
   output logic                                       rsp_set_done,
   input  wire logic                                  csr_wr_en,
   input  wire logic [pmns_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [pmns_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import pmns_pkg::*;

   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int FLUSH_LEN = SLOTS + RETURN_DELAY;

   // Configuration registers.
   logic [MAP_LOW_W-1:0]  map_low_ff;
   logic [MAP_HIGH_W-1:0] map_high_ff;
   logic                  flt_en_ff;
   pmns_coef_type         coef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_low_ff       <= MAP_LOW_RST;
         map_high_ff      <= MAP_HIGH_RST;
         flt_en_ff        <= 1'b1;
         coef_ff.b_outer  <= B_OUTER_RST;
         coef_ff.b_mid    <= B_MID_RST;
         coef_ff.fb_near  <= FB_NEAR_RST;
         coef_ff.fb_far   <= FB_FAR_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CHAN_MAP_LOW:  map_low_ff      <= csr_wdata[MAP_LOW_W-1:0];
            CSR_CHAN_MAP_HIGH: map_high_ff     <= csr_wdata[MAP_HIGH_W-1:0];
            CSR_FILTER_ENABLE: flt_en_ff       <= csr_wdata[0];
            CSR_COEF_B_OUTER:  coef_ff.b_outer <= csr_wdata[15:0];
            CSR_COEF_B_MID:    coef_ff.b_mid   <= csr_wdata[15:0];
            CSR_COEF_FB_NEAR:  coef_ff.fb_near <= csr_wdata[15:0];
            CSR_COEF_FB_FAR:   coef_ff.fb_far  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Pipeline occupancy and movement.
   logic s1_v_ff, s2_v_ff, rsp_valid_ff;
   logic out_free, s2_mv, s2_free, s1_mv, s1_free, accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s2_mv     = s2_v_ff && out_free;
   assign s2_free   = !s2_v_ff || s2_mv;
   assign s1_mv     = s1_v_ff && s2_free;
   assign s1_free   = !s1_v_ff || s1_mv;
   assign req_stall = !s1_free;
   assign accept    = req_valid && s1_free;

   // Sequencer state: command slot, in-flight slots, flush and set counters.
   logic [SLOT_W-1:0] cmd_slot_ff, cmd_slot_in;
   logic [SLOT_W-1:0] fly_ff [RETURN_DELAY];
   logic              flushing_ff;
   logic [4:0]        flush_count_ff, flush_count_in;
   logic [3:0]        set_count_ff, set_count_in;
   logic [4:0]        set_next;
   logic              done_in;
   logic [MAP_LOW_W+MAP_HIGH_W-1:0] map_all;
   logic [CHAN_W-1:0] chan_tab [MAP_SLOTS];
   logic [WORD_W-1:0] cmd_in;

   always_comb begin
      // Slot i's channel number sits in bits 6i+5..6i of the joined map.
      map_all = {map_high_ff, map_low_ff};
      for (int i = 0; i < MAP_SLOTS; i++) begin
         chan_tab[i] = map_all[CHAN_W*i +: CHAN_W];
      end
      cmd_in = {2'b00, chan_tab[SLOT_PORT_W'(cmd_slot_ff)], 8'h00};
      cmd_slot_in = (cmd_slot_ff == SLOT_W'(SLOTS - 1)) ? '0 : cmd_slot_ff + 1'b1;
      flush_count_in = flush_count_ff + 5'd1;
      set_next = {1'b0, set_count_ff} + 5'd1;
      done_in  = !flushing_ff && (set_next >= 5'(SLOTS));
      set_count_in = done_in ? 4'd0 : set_next[3:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_slot_ff    <= '0;
         flushing_ff    <= 1'b1;
         flush_count_ff <= '0;
         set_count_ff   <= '0;
         for (int i = 0; i < RETURN_DELAY; i++) begin
            fly_ff[i] <= '0;
         end
      end else if (accept) begin
         cmd_slot_ff <= cmd_slot_in;
         for (int i = 0; i < RETURN_DELAY - 1; i++) begin
            fly_ff[i] <= fly_ff[i+1];
         end
         fly_ff[RETURN_DELAY-1] <= cmd_slot_ff;
         if (flushing_ff) begin
            flush_count_ff <= flush_count_in;
            if (flush_count_in >= 5'(FLUSH_LEN)) begin
               flushing_ff <= 1'b0;
            end
         end else begin
            set_count_ff <= set_count_in;
         end
      end
   end

   // Stage registers. The item's slot is the oldest in-flight command.
   logic [WORD_W-1:0]        s1_cmd_ff, s2_cmd_ff;
   logic                     s1_sval_ff, s2_sval_ff;
   logic                     s1_done_ff, s2_done_ff;
   logic                     s1_run_ff, s2_run_ff;
   logic [SLOT_W-1:0]        s1_slot_ff, s2_slot_ff;
   logic signed [WORD_W-1:0] s1_word_ff, s2_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_v_ff <= req_valid;
         end
         if (s2_free) begin
            s2_v_ff <= s1_v_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= s2_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff  <= cmd_in;
         s1_sval_ff <= !flushing_ff;
         s1_done_ff <= done_in;
         s1_run_ff  <= !flushing_ff && flt_en_ff;
         s1_slot_ff <= fly_ff[0];
         s1_word_ff <= req_rx_word;
      end
      if (s1_mv) begin
         s2_cmd_ff  <= s1_cmd_ff;
         s2_sval_ff <= s1_sval_ff;
         s2_done_ff <= s1_done_ff;
         s2_run_ff  <= s1_run_ff;
         s2_slot_ff <= s1_slot_ff;
         s2_word_ff <= s1_word_ff;
      end
   end

   // Filter datapath around the history memory.
   pmns_ctl_type             ctl;
   logic signed [WORD_W-1:0] notch_sample;

   assign ctl.rd_en   = accept;
   assign ctl.s1_load = s1_mv;
   assign ctl.wr_en   = s2_mv && s2_run_ff;

   pmns_notch #(
      .SLOTS (SLOTS)
   ) u_notch (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .rd_slot (fly_ff[0]),
      .wr_slot (s2_slot_ff),
      .coef    (coef_ff),
      .x_new   (s1_word_ff),
      .sample  (notch_sample)
   );

   // Output register.
   logic [WORD_W-1:0]        out_cmd_ff;
   logic                     out_sval_ff;
   logic [SLOT_PORT_W-1:0]   out_slot_ff;
   logic signed [WORD_W-1:0] out_sample_ff;
   logic                     out_done_ff;

   always_ff @(posedge clock) begin
      if (s2_mv) begin
         out_cmd_ff  <= s2_cmd_ff;
         out_sval_ff <= s2_sval_ff;
         out_done_ff <= s2_done_ff;
         out_slot_ff <= s2_sval_ff ? SLOT_PORT_W'(s2_slot_ff) : '0;
         if (!s2_sval_ff) begin
            out_sample_ff <= '0;
         end else if (s2_run_ff) begin
            out_sample_ff <= notch_sample;
         end else begin
            out_sample_ff <= s2_word_ff;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_next_cmd        = out_cmd_ff;
   assign rsp_sample_valid    = out_sval_ff;
   assign rsp_sample_slot     = out_slot_ff;
   assign rsp_filtered_sample = out_sample_ff;
   assign rsp_set_done        = out_done_ff;

   // A sample is only ever produced once the flush is over.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sample_valid |-> !flushing_ff)
      else $error("sample delivered while still flushing");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_set_done |-> rsp_sample_valid)
      else $error("set marker on a flush item");

   assert property (@(posedge clock) disable iff (reset)
      !flushing_ff |=> !flushing_ff)
      else $error("flush restarted without reset");

   // Two samples in adjacent stages always belong to different slots.
   assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && s2_v_ff && s1_sval_ff && s2_sval_ff |-> s1_slot_ff != s2_slot_ff)
      else $error("adjacent stages carry the same slot");

endmodule

`default_nettype wire

/* src/pmns_notch.sv */
`default_nettype none

module pmns_notch #(
   parameter int SLOTS = pmns_pkg::SLOTS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire pmns_pkg::pmns_ctl_type                ctl,
   input  wire logic [$clog2(SLOTS)-1:0]              rd_slot,
   input  wire logic [$clog2(SLOTS)-1:0]              wr_slot,
   input  wire pmns_pkg::pmns_coef_type               coef,
   input  wire logic signed [pmns_pkg::WORD_W-1:0]    x_new,
   output logic signed [pmns_pkg::WORD_W-1:0]         sample
);
   import pmns_pkg::*;

   // History store, one entry per slot, and a valid bit per entry so that
   // an entry never written reads as zero history.
   pmns_hist_type     mem [SLOTS];
   logic [SLOTS-1:0]  vld_ff;
   pmns_hist_type     rd_ff;
   logic              rd_ok_ff;
   pmns_hist_type     hist;

   // Stage 1 products and the values carried to write-back.
   logic signed [16:0] xsum;
   logic signed [32:0] pb_in, pb_ff;
   logic signed [31:0] pm_in, pm_ff;
   logic signed [47:0] pn_in, pn_ff;
   logic signed [47:0] pf_in, pf_ff;
   logic signed [15:0] x1_ff, x2_ff;
   logic signed [31:0] y1_ff;

   // Stage 2 accumulate and scaling.
   logic signed [49:0] acc;
   logic signed [35:0] yw;
   logic signed [31:0] ysat;
   logic        [23:0] q24;
   logic               ovf32, ovf16;

   // Synchronous read, registered when an item enters.
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_ff    <= mem[rd_slot];
         rd_ok_ff <= vld_ff[rd_slot];
      end
      if (ctl.wr_en) begin
         mem[wr_slot] <= '{x0: x1_ff, x1: x2_ff, y0: y1_ff, y1: ysat};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl.wr_en) begin
         vld_ff[wr_slot] <= 1'b1;
      end
   end

   assign hist = rd_ok_ff ? rd_ff : '0;

   // Four products, one multiplier each, registered before the sum.
   always_comb begin
      xsum  = 17'(hist.x0) + 17'(x_new);
      pb_in = 33'(coef.b_outer) * 33'(xsum);
      pm_in = 32'(coef.b_mid) * 32'(hist.x1);
      pn_in = 48'(coef.fb_near) * 48'(hist.y1);
      pf_in = 48'(coef.fb_far) * 48'(hist.y0);
   end

   always_ff @(posedge clock) begin
      if (ctl.s1_load) begin
         pb_ff <= pb_in;
         pm_ff <= pm_in;
         pn_ff <= pn_in;
         pf_ff <= pf_in;
         x1_ff <= hist.x1;
         x2_ff <= x_new;
         y1_ff <= hist.y1;
      end
   end

   // Q.22 sum, floor to Q.8, clamp to 32 bits, then truncate toward zero
   // to an integer and clamp to 16 bits.
   always_comb begin
      acc   = ((50'(pb_ff) + 50'(pm_ff)) <<< 8) + 50'(pn_ff) + 50'(pf_ff);
      yw    = acc[49:14];
      ovf32 = (yw[35:31] != {5{yw[35]}});
      if (ovf32) begin
         ysat = yw[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         ysat = yw[31:0];
      end
      q24   = ysat[31:8] + {23'd0, (ysat[31] && (ysat[7:0] != 8'd0))};
      ovf16 = (q24[23:15] != {9{q24[23]}});
      if (ovf16) begin
         sample = q24[23] ? 16'sh8000 : 16'sh7FFF;
      end else begin
         sample = q24[15:0];
      end
   end

   // Consecutive items never share a slot, so a read and a write-back never
   // meet on one entry.
   assert property (@(posedge clock) disable iff (reset)
      ctl.rd_en && ctl.wr_en |-> rd_slot != wr_slot)
      else $error("history read and write-back hit the same slot");

   assert property (@(posedge clock) disable iff (reset)
      ctl.wr_en |=> vld_ff[$past(wr_slot)])
      else $error("history entry not marked valid after write-back");

   assert property (@(posedge clock) disable iff (reset)
      ctl.rd_en |=> rd_ok_ff == $past(vld_ff[rd_slot]))
      else $error("history read lost the entry's valid bit");

endmodule

`default_nettype wire

/* dv/pipelined_multichannel_notch_sampler_tb.sv */
`default_nettype none

module pipelined_multichannel_notch_sampler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pmns_pkg::*;

   localparam int SLOTS       = SLOTS_DEF;
   localparam int RDELAY      = RETURN_DELAY_DEF;
   localparam int LATENCY     = 3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_LIMIT = 100;

   // The one index of the port that maps to no register.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   localparam longint Y_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam longint Y_MIN = -64'sh0000_0000_8000_0000;

   // One frame result as it leaves the block.
   typedef struct packed {
      logic [WORD_W-1:0]        next_cmd;
      logic                     sample_valid;
      logic [SLOT_PORT_W-1:0]   sample_slot;
      logic signed [WORD_W-1:0] filtered_sample;
      logic                     set_done;
   } frame_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic signed [WORD_W-1:0]        req_rx_word = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [WORD_W-1:0]               rsp_next_cmd;
   logic                            rsp_sample_valid;
   logic [SLOT_PORT_W-1:0]          rsp_sample_slot;
   logic signed [WORD_W-1:0]        rsp_filtered_sample;
   logic                            rsp_set_done;
   logic                            csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]            csr_index = '0;
   logic [CSR_DATA_W-1:0]           csr_wdata = '0;

   pipelined_multichannel_notch_sampler dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_word         (req_rx_word),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_next_cmd        (rsp_next_cmd),
      .rsp_sample_valid    (rsp_sample_valid),
      .rsp_sample_slot     (rsp_sample_slot),
      .rsp_filtered_sample (rsp_filtered_sample),
      .rsp_set_done        (rsp_set_done),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // Register copies of the sampler model.
   logic [MAP_LOW_W-1:0]     map_low;
   logic [MAP_HIGH_W-1:0]    map_high;
   logic                     notch_on;
   logic signed [15:0]       b_outer;
   logic signed [15:0]       b_mid;
   logic signed [15:0]       fb_near;
   logic signed [15:0]       fb_far;

   // Sequencer and filter state of the sampler model.
   bit                       flushing;
   int unsigned              flush_count;
   int unsigned              cmd_slot;
   int unsigned              inflight[RDELAY];
   int unsigned              set_count;
   logic signed [15:0]       x_hist[SLOTS*2];
   logic signed [31:0]       y_hist[SLOTS*2];

   frame_result_type         expected_frames[$];
   int                       error_count = 0;
   int                       cycle_count = 0;
   int                       hold_cycles = 0;
   bit                       calm = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic flag_error(input string msg);
      if (error_count < PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic void model_reset();
      map_low     = MAP_LOW_RST;
      map_high    = MAP_HIGH_RST;
      notch_on    = 1'b1;
      b_outer     = B_OUTER_RST;
      b_mid       = B_MID_RST;
      fb_near     = FB_NEAR_RST;
      fb_far      = FB_FAR_RST;
      flushing    = 1'b1;
      flush_count = 0;
      cmd_slot    = 0;
      set_count   = 0;
      foreach (inflight[i]) inflight[i] = 0;
      foreach (x_hist[i]) x_hist[i] = '0;
      foreach (y_hist[i]) y_hist[i] = '0;
   endfunction

   function automatic void model_config(input logic [CSR_IDX_W-1:0] idx,
                                        input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_CHAN_MAP_LOW:  map_low  = data[MAP_LOW_W-1:0];
         CSR_CHAN_MAP_HIGH: map_high = data[MAP_HIGH_W-1:0];
         CSR_FILTER_ENABLE: notch_on = data[0];
         CSR_COEF_B_OUTER:  b_outer  = data[15:0];
         CSR_COEF_B_MID:    b_mid    = data[15:0];
         CSR_COEF_FB_NEAR:  fb_near  = data[15:0];
         CSR_COEF_FB_FAR:   fb_far   = data[15:0];
         default: ;
      endcase
   endfunction

   function automatic logic [CHAN_W-1:0] slot_channel(input int unsigned s);
      if (s < LOW_SLOTS)
         return map_low[CHAN_W*s +: CHAN_W];
      return map_high[CHAN_W*((s - LOW_SLOTS) % 8) +: CHAN_W];
   endfunction

   // One biquad step of a slot: Q.22 sum, floor to Q.8, clamp, then to int16.
   function automatic logic signed [15:0] notch_step(input int unsigned s,
                                                     input logic signed [15:0] x2);
      int unsigned b;
      longint acc, y, q;
      b = s * 2;
      acc = 256 * (longint'(b_outer) * (longint'(x_hist[b]) + longint'(x2))
                   + longint'(b_mid) * longint'(x_hist[b+1]))
            + longint'(fb_near) * longint'(y_hist[b+1])
            + longint'(fb_far) * longint'(y_hist[b]);
      y = acc >>> 14;
      if (y > Y_MAX) y = Y_MAX;
      if (y < Y_MIN) y = Y_MIN;
      x_hist[b]   = x_hist[b+1];
      x_hist[b+1] = x2;
      y_hist[b]   = y_hist[b+1];
      y_hist[b+1] = y[31:0];
      q = y / 256;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   // Advances the sampler model by one frame and returns what it emits.
   function automatic frame_result_type predict_frame(input logic signed [15:0] word);
      frame_result_type r;
      int unsigned head;
      head = inflight[0] % SLOTS;
      r = '0;
      r.next_cmd = 16'(slot_channel(cmd_slot % SLOTS)) << 8;
      for (int i = 0; i + 1 < RDELAY; i++)
         inflight[i] = inflight[i+1];
      inflight[RDELAY-1] = cmd_slot % SLOTS;
      cmd_slot = (cmd_slot + 1) % SLOTS;
      if (flushing) begin
         flush_count = (flush_count + 1) & 31;
         if (flush_count >= SLOTS + RDELAY)
            flushing = 1'b0;
      end else begin
         r.filtered_sample = notch_on ? notch_step(head, word) : word;
         r.sample_valid = 1'b1;
         r.sample_slot  = head[SLOT_PORT_W-1:0];
         set_count = (set_count + 1) & 15;
         if (set_count >= SLOTS || set_count == 0) begin
            r.set_done = 1'b1;
            set_count  = 0;
         end
      end
      return r;
   endfunction

   // Every accepted item moves the model one frame.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         expected_frames.push_back(predict_frame(req_rx_word));
   end

   // Every accepted result is matched against the oldest prediction.
   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_frames.size() == 0) begin
            flag_error($sformatf("result with nothing expected, next_cmd %h", rsp_next_cmd));
         end else begin
            want = expected_frames.pop_front();
            if (rsp_next_cmd !== want.next_cmd)
               flag_error($sformatf("next_cmd %h, expected %h", rsp_next_cmd, want.next_cmd));
            if (rsp_sample_valid !== want.sample_valid)
               flag_error($sformatf("sample_valid %b, expected %b",
                                    rsp_sample_valid, want.sample_valid));
            if (rsp_sample_slot !== want.sample_slot)
               flag_error($sformatf("sample_slot %0d, expected %0d",
                                    rsp_sample_slot, want.sample_slot));
            if (rsp_filtered_sample !== want.filtered_sample)
               flag_error($sformatf("filtered_sample %0d, expected %0d",
                                    rsp_filtered_sample, want.filtered_sample));
            if (rsp_set_done !== want.set_done)
               flag_error($sformatf("set_done %b, expected %b", rsp_set_done, want.set_done));
         end
      end
   end

   // Receiver stalls: a requested hold-off first, else random unless calm.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles--;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 16);
      end
   end

   // Watchdog on the whole run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [59:0] rand60();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[59:0];
   endfunction

   // Random words, weighted toward the rails and toward values near zero.
   function automatic logic signed [15:0] rand_word();
      case ($urandom_range(0, 9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'(int'($urandom_range(0, 32)) - 16);
         default: return 16'($urandom);
      endcase
   endfunction

   // Fills the bits above a register's width with junk that the block must drop.
   function automatic logic [59:0] pad_junk(input logic [59:0] v, input int w);
      logic [59:0] mask;
      mask = (60'd1 << w) - 60'd1;
      return (rand60() & ~mask) | (v & mask);
   endfunction

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      model_config(idx, data);
   endtask

   task automatic program_setting(input logic [59:0] lo, input logic [35:0] hi,
                                  input logic fen, input logic signed [15:0] bo,
                                  input logic signed [15:0] bm, input logic signed [15:0] fn,
                                  input logic signed [15:0] ff);
      csr_write(CSR_CHAN_MAP_LOW, lo);
      csr_write(CSR_CHAN_MAP_HIGH, pad_junk(60'(hi), MAP_HIGH_W));
      csr_write(CSR_FILTER_ENABLE, pad_junk(60'(fen), 1));
      csr_write(CSR_COEF_B_OUTER, pad_junk(60'(bo), 16));
      csr_write(CSR_COEF_B_MID, pad_junk(60'(bm), 16));
      csr_write(CSR_COEF_FB_NEAR, pad_junk(60'(fn), 16));
      csr_write(CSR_COEF_FB_FAR, pad_junk(60'(ff), 16));
      // An index past the register list must leave everything as it is.
      csr_write(CSR_UNUSED, rand60());
   endtask

   // Offers one item, with a random gap before it unless calm.
   task automatic send_frame(input logic signed [15:0] word);
      if (!calm) begin
         while ($urandom_range(0, 99) < 16) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_rx_word <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stops offering and waits until every predicted result has come back.
   task automatic drain_all();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic send_random(input int n);
      repeat (n) send_frame(rand_word());
   endtask

   // Reset values; the flush frames and the first filtered frames see the rails.
   task automatic test_flush_and_extremes();
      logic signed [15:0] words[18];
      words = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh7FFF,
                16'sh8000, 16'sh5555, 16'shAAAA, 16'sh0000, 16'sh7FFF, 16'sh7FFF,
                16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'shFFFF, 16'sh0000};
      foreach (words[i]) send_frame(words[i]);
      drain_all();
   endtask

   // Filter off: the raw word must come through, with junk above bit 0.
   task automatic test_filter_bypass();
      logic signed [15:0] words[6];
      words = '{16'sh7FFF, 16'sh8000, 16'shFFFF, 16'sh0000, 16'sh1234, 16'shEDCB};
      csr_write(CSR_FILTER_ENABLE, 60'hFFF_FFFF_FFFF_FFFE);
      foreach (words[i]) send_frame(words[i]);
      drain_all();
      // Turning the notch back on resumes the histories left untouched.
      csr_write(CSR_FILTER_ENABLE, 60'd1);
      send_random(100);
      drain_all();
      csr_write(CSR_FILTER_ENABLE, 60'd0);
      send_random(100);
      drain_all();
   endtask

   // Random maps and gains; the first run keeps the stock notch gains.
   task automatic test_random_settings();
      program_setting(rand60(), 36'(rand60()), 1'b1, B_OUTER_RST, B_MID_RST,
                      FB_NEAR_RST, FB_FAR_RST);
      send_random(100);
      drain_all();
      repeat (3) begin
         program_setting(rand60(), 36'(rand60()), 1'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom), 16'($urandom));
         send_random(100);
         drain_all();
      end
   endtask

   // Gains at the rails drive the Q.8 history and the output into saturation.
   task automatic test_coef_extremes();
      program_setting({60{1'b1}}, {36{1'b1}}, 1'b1, 16'sh7FFF, 16'sh7FFF,
                      16'sh7FFF, 16'sh7FFF);
      send_random(100);
      drain_all();
      program_setting('0, '0, 1'b1, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_random(100);
      drain_all();
      program_setting(rand60(), 36'(rand60()), 1'b1, 16'sh7FFF, 16'sh8000,
                      16'sh7FFF, 16'sh8000);
      send_random(100);
      drain_all();
   endtask

   // Long receiver hold-off while items keep coming, then a full pause.
   task automatic test_backpressure();
      program_setting(MAP_LOW_RST, MAP_HIGH_RST, 1'b1, B_OUTER_RST, B_MID_RST,
                      FB_NEAR_RST, FB_FAR_RST);
      calm = 1'b1;
      hold_cycles = 80;
      send_random(30);
      calm = 1'b0;
      drain_all();
      send_random(60);
      drain_all();
   endtask

   // Back-to-back items with the receiver always ready.
   task automatic test_steady_stream();
      calm = 1'b1;
      send_random(200);
      drain_all();
      calm = 1'b0;
   endtask

   initial begin
      model_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_flush_and_extremes();
      test_filter_bypass();
      test_random_settings();
      test_coef_extremes();
      test_backpressure();
      test_steady_stream();
      repeat (LATENCY + 4) @(posedge clock);
      if (error_count == 0 && expected_frames.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
